/* rtl/core/utrd_pkg.sv */
package utrd_pkg;

   localparam int VALUE_W = 32;
   localparam int RADIX_W = 5;
   localparam int PAD_W   = 4;
   localparam int CHAR_W  = 7;
   localparam int DIGIT_W = 4;
   localparam int REM_W   = 5;
   localparam int STEP_W  = 5;

   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);
   localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(VALUE_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_STORE,
      ST_EMIT_INIT,
      ST_EMIT
   } utrd_state_type;

   typedef struct packed {
      logic load;
      logic set_dropped;
      logic div_start;
      logic div_step;
      logic store_digit;
      logic emit_init;
      logic emit_next;
   } utrd_cmd_type;

   typedef struct packed {
      logic div_last;
      logic quot_zero;
      logic pos_zero;
      logic emit_last;
   } utrd_status_type;

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] digit);
      logic [CHAR_W-1:0] ch;
      if (digit < DIGIT_W'(10)) begin
         ch = CHAR_W'(7'h30) + CHAR_W'(digit);
      end else begin
         ch = CHAR_W'(7'h37) + CHAR_W'(digit);
      end
      return ch;
   endfunction

endpackage

/* rtl/core/utrd_ctrl.sv */
module utrd_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  utrd_pkg::utrd_status_type status,
   output utrd_pkg::utrd_cmd_type    cmd
);
   import utrd_pkg::*;

   utrd_state_type state_ff;
   utrd_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.pos_zero) begin
               state_in = ST_EMIT_INIT;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            if (status.quot_zero) begin
               state_in = ST_EMIT_INIT;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_EMIT_INIT: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_stall && status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_CHECK: begin
            cmd.set_dropped = status.pos_zero;
            cmd.div_start   = !status.pos_zero;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_STORE: begin
            cmd.store_digit = 1'b1;
         end
         ST_EMIT_INIT: begin
            cmd.emit_init = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid     = 1'b1;
            cmd.emit_next = !rsp_stall && !status.emit_last;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* rtl/core/utrd_datapath.sv */
module utrd_datapath #(
   parameter int MAX_DIGITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  utrd_pkg::utrd_cmd_type               cmd,
   output utrd_pkg::utrd_status_type            status,
   input  logic [utrd_pkg::VALUE_W-1:0]         req_value,
   input  logic [utrd_pkg::RADIX_W-1:0]         req_radix,
   input  logic [utrd_pkg::PAD_W-1:0]           req_pad_width,
   output logic [utrd_pkg::CHAR_W-1:0]          rsp_digit_char,
   output logic                                 rsp_last_char,
   output logic                                 rsp_digits_dropped
);
   import utrd_pkg::*;

   localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int PW = $clog2(MAX_DIGITS + 1);

   logic [DIGIT_W-1:0] store_ff [MAX_DIGITS];
   logic [VALUE_W-1:0] quot_ff;
   logic [VALUE_W-1:0] quot_in;
   logic [REM_W-1:0]   rem_ff;
   logic [REM_W-1:0]   rem_in;
   logic [REM_W-1:0]   rem_shift;
   logic               rem_ge;
   logic [RADIX_W-1:0] radix_ff;
   logic [RADIX_W-1:0] radix_in;
   logic [PW-1:0]      width_ff;
   logic [PW-1:0]      width_in;
   logic [PW-1:0]      pos_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [IW-1:0]      ptr_ff;
   logic [IW-1:0]      ptr_first;
   logic               dropped_ff;

   // saturate the operands on load
   always_comb begin
      radix_in = req_radix;
      if (req_radix < RADIX_MIN) begin
         radix_in = RADIX_MIN;
      end else if (req_radix > RADIX_MAX) begin
         radix_in = RADIX_MAX;
      end
      if (int'(req_pad_width) > MAX_DIGITS) begin
         width_in = PW'(MAX_DIGITS);
      end else begin
         width_in = PW'(req_pad_width);
      end
   end

   // one restoring division step
   always_comb begin
      rem_shift = {rem_ff[REM_W-2:0], quot_ff[VALUE_W-1]};
      rem_ge    = (rem_shift >= REM_W'(radix_ff));
      rem_in    = rem_ge ? (rem_shift - REM_W'(radix_ff)) : rem_shift;
      quot_in   = {quot_ff[VALUE_W-2:0], rem_ge};
   end

   always_comb begin
      if (dropped_ff) begin
         ptr_first = '0;
      end else if (width_ff != '0) begin
         ptr_first = IW'(PW'(MAX_DIGITS) - width_ff);
      end else begin
         ptr_first = IW'(pos_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         step_ff    <= '0;
         ptr_ff     <= '0;
         dropped_ff <= 1'b0;
         for (int i = 0; i < MAX_DIGITS; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         if (cmd.load) begin
            pos_ff     <= PW'(MAX_DIGITS);
            dropped_ff <= 1'b0;
            for (int i = 0; i < MAX_DIGITS; i++) begin
               store_ff[i] <= '0;
            end
         end
         if (cmd.set_dropped) begin
            dropped_ff <= 1'b1;
         end
         if (cmd.div_start) begin
            step_ff <= '0;
         end
         if (cmd.div_step) begin
            step_ff <= step_ff + STEP_W'(1);
         end
         if (cmd.store_digit) begin
            store_ff[IW'(pos_ff - PW'(1))] <= rem_ff[DIGIT_W-1:0];
            pos_ff <= pos_ff - PW'(1);
         end
         if (cmd.emit_init) begin
            ptr_ff <= ptr_first;
         end
         if (cmd.emit_next) begin
            ptr_ff <= ptr_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         quot_ff  <= req_value;
         radix_ff <= radix_in;
         width_ff <= width_in;
      end
      if (cmd.div_start) begin
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   always_comb begin
      status.div_last  = (step_ff == STEP_LAST);
      status.quot_zero = (quot_ff == '0);
      status.pos_zero  = (pos_ff == '0);
      status.emit_last = (ptr_ff == IW'(MAX_DIGITS - 1));
   end

   assign rsp_digit_char     = digit_to_char(store_ff[ptr_ff]);
   assign rsp_last_char      = status.emit_last;
   assign rsp_digits_dropped = dropped_ff;

endmodule

/* rtl/core/unsigned_to_radix_digits.sv */
// Converts a 32-bit unsigned word into ASCII digits ('0'-'9', 'A'-'F') in a radix
// of 2 to 16, most significant first, one character per output word, with
// rsp_last_char on the final one. pad_width 0 gives the significant digits only
// (a single '0' for zero); a nonzero pad_width gives exactly that many low
// positions, zero padded or truncated. If the value needs more than MAX_DIGITS
// digits, the low MAX_DIGITS are sent, whatever the pad width, with
// rsp_digits_dropped set. Radix and pad width saturate to their legal ranges.
// One word is converted at a time: each digit takes one check, 32 shift-subtract
// steps and one store in the bit-serial restoring divider; once all digits are
// stored, the characters go out, one character per cycle while the output is
// not stalled.
module unsigned_to_radix_digits #(
   parameter int MAX_DIGITS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [utrd_pkg::VALUE_W-1:0] req_value,
   input  logic [utrd_pkg::RADIX_W-1:0] req_radix,
   input  logic [utrd_pkg::PAD_W-1:0]   req_pad_width,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [utrd_pkg::CHAR_W-1:0]  rsp_digit_char,
   output logic                         rsp_last_char,
   output logic                         rsp_digits_dropped
);
   import utrd_pkg::*;

   utrd_cmd_type    cmd;
   utrd_status_type status;

   utrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   utrd_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_value          (req_value),
      .req_radix          (req_radix),
      .req_pad_width      (req_pad_width),
      .rsp_digit_char     (rsp_digit_char),
      .rsp_last_char      (rsp_last_char),
      .rsp_digits_dropped (rsp_digits_dropped)
   );

   // no new word taken while characters are going out
   a_no_accept_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted during emit");

   // a conversion never produces a character in the cycle after its word is taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid)
      else $error("result before conversion");

   // last character ends the run
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_char) |=> !rsp_valid)
      else $error("characters after last");

   // dropped flag is the same across a run
   a_dropped_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid)) |-> $stable(rsp_digits_dropped))
      else $error("dropped flag changed within run");

endmodule
